>>> rtl/core/tgw_pkg.sv
// ============================================================================
// tgw_pkg
// Shared types, constants and helper functions for the torus grid walker.
// ============================================================================
package tgw_pkg;

    // Grid geometry. Cells are addressed as {column, row}.
    localparam int GRID_SIDE  = 256;
    localparam int CRD_W      = $clog2(GRID_SIDE);
    localparam int ADDR_W     = 2 * CRD_W;
    localparam int CELL_W     = 8;
    localparam int AREA_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CRD_W-1:0] SIDE_MAX = CRD_W'(GRID_SIDE - 1);

    // Operation codes of an input transaction.
    localparam logic [1:0] OP_STEP  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_PLACE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // Directions.
    localparam logic [1:0] DIR_RIGHT = 2'd0;
    localparam logic [1:0] DIR_UP    = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    // Strategy codes.
    localparam logic [2:0] STRAT_RANDOM   = 3'd0;
    localparam logic [2:0] STRAT_NOBACK   = 3'd1;
    localparam logic [2:0] STRAT_GREEDY_B = 3'd2;
    localparam logic [2:0] STRAT_GREEDY_U = 3'd3;
    localparam logic [2:0] STRAT_CBLIND   = 3'd4;
    localparam logic [2:0] STRAT_FOLLOW   = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STRATEGY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AGENT_MARK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MINE_MARK  = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [2:0]        RST_STRATEGY   = STRAT_RANDOM;
    localparam logic [CELL_W-1:0] RST_AGENT_MARK = 8'd1;
    localparam logic [CELL_W-1:0] RST_MINE_MARK  = 8'd255;

    // Candidate order of the non-backtracking walk: right, left, down, up.
    localparam logic [3:0][1:0] NB_ORDER = {DIR_UP, DIR_DOWN, DIR_LEFT, DIR_RIGHT};

    // Input transaction payload.
    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  cell_x;
        logic [7:0]  cell_y;
        logic [7:0]  cell_value;
        logic [15:0] random_value;
    } t_item;

    // Result transaction payload.
    typedef struct packed {
        logic [7:0]  pos_x;
        logic [7:0]  pos_y;
        logic [1:0]  chosen_direction;
        logic        moved;
        logic [31:0] area_count;
        logic [7:0]  read_data;
    } t_result;

    // Request to the direction picker: neighbor cells and walker state.
    typedef struct packed {
        logic [3:0][CELL_W-1:0] cells;
        logic [2:0]             strategy;
        logic [1:0]             heading;
        logic [CELL_W-1:0]      agent_mark;
        logic [CELL_W-1:0]      mine_mark;
        logic [1:0]             rnd_lo;
        logic [1:0]             rnd_mod3;
    } t_pick_req;

    // Answer of the direction picker.
    typedef struct packed {
        logic [1:0] dir;
        logic       heading_we;
        logic [1:0] heading;
    } t_pick_rsp;

    // Neighbor coordinate with wrap at the grid edge.
    function automatic logic [CRD_W-1:0] coord_inc(input logic [CRD_W-1:0] c);
        return (c == SIDE_MAX) ? '0 : c + 1'b1;
    endfunction

    function automatic logic [CRD_W-1:0] coord_dec(input logic [CRD_W-1:0] c);
        return (c == '0) ? SIDE_MAX : c - 1'b1;
    endfunction

    function automatic logic [CRD_W-1:0] target_x(input logic [CRD_W-1:0] x,
                                                  input logic [1:0] d);
        logic [CRD_W-1:0] t;
        t = x;
        if (d == DIR_RIGHT) t = coord_inc(x);
        if (d == DIR_LEFT)  t = coord_dec(x);
        return t;
    endfunction

    function automatic logic [CRD_W-1:0] target_y(input logic [CRD_W-1:0] y,
                                                  input logic [1:0] d);
        logic [CRD_W-1:0] t;
        t = y;
        if (d == DIR_UP)   t = coord_inc(y);
        if (d == DIR_DOWN) t = coord_dec(y);
        return t;
    endfunction

    // Number of set bits in a four-bit mask.
    function automatic logic [2:0] count4(input logic [3:0] m);
        return 3'(m[0]) + 3'(m[1]) + 3'(m[2]) + 3'(m[3]);
    endfunction

    // Position of the k-th set bit of a mask, counted from bit zero.
    function automatic logic [1:0] sel_nth(input logic [3:0] m, input logic [1:0] k);
        logic [2:0] seen;
        logic [1:0] pos;
        seen = '0;
        pos  = '0;
        for (int i = 0; i < 4; i++) begin
            if (m[i]) begin
                if (seen == 3'(k)) pos = 2'(i);
                seen = seen + 1'b1;
            end
        end
        return pos;
    endfunction

    // Random index among n candidates, n from one to four.
    function automatic logic [1:0] rand_idx(input logic [2:0] n, input logic [1:0] lo,
                                            input logic [1:0] m3);
        logic [1:0] k;
        unique case (n)
            3'd1:    k = 2'd0;
            3'd2:    k = {1'b0, lo[0]};
            3'd3:    k = m3;
            default: k = lo;
        endcase
        return k;
    endfunction

    // Remainder modulo three of a 16-bit value. Every base-4 digit has
    // weight one modulo three, so the digits are summed and folded.
    function automatic logic [1:0] mod3_u16(input logic [15:0] v);
        logic [4:0] s;
        logic [2:0] t;
        logic [2:0] u;
        s = '0;
        for (int i = 0; i < 8; i++) begin
            s = s + 5'(v[2*i +: 2]);
        end
        t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        u = 3'(t[1:0]) + 3'(t[2]);
        if (u >= 3'd3) u = u - 3'd3;
        return u[1:0];
    endfunction

endpackage

>>> rtl/core/tgw_grid_ram.sv
// ============================================================================
// tgw_grid_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ============================================================================
module tgw_grid_ram #(
    parameter int ADDR_W = 16,
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data registered while the read enable is high.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

>>> rtl/core/tgw_dir_pick.sv
// ============================================================================
// tgw_dir_pick
// Chooses the step direction from the four neighbor cells by strategy.
// ============================================================================
module tgw_dir_pick (
    input  tgw_pkg::t_pick_req i_req,
    output tgw_pkg::t_pick_rsp o_rsp
);

    logic [3:0] mine;
    logic [3:0] free;
    logic [3:0] blank;
    logic [3:0] open;
    logic [3:0] nb_mask;
    logic [2:0] n_free;
    logic [2:0] n_blank;
    logic [2:0] n_nb;
    logic [1:0] rw_dir;
    logic [1:0] nb_dir;
    logic [1:0] gb_dir;
    logic [1:0] gu_dir;
    logic [1:0] h;
    logic [1:0] h_left;
    logic [1:0] h_right;
    logic [1:0] h_back;

    // Classify the neighbors.
    always_comb begin
        for (int d = 0; d < 4; d++) begin
            mine[d]  = (i_req.cells[d] == i_req.mine_mark);
            blank[d] = (i_req.cells[d] == '0);
            open[d]  = (i_req.cells[d] != i_req.agent_mark) && !mine[d];
        end
        free = ~mine;
        for (int i = 0; i < 4; i++) begin
            nb_mask[i] = free[tgw_pkg::NB_ORDER[i]] && (tgw_pkg::NB_ORDER[i] != i_req.heading);
        end
    end

    assign n_free  = tgw_pkg::count4(free);
    assign n_blank = tgw_pkg::count4(blank);
    assign n_nb    = tgw_pkg::count4(nb_mask);

    assign h       = i_req.heading;
    assign h_left  = h + 2'd1;
    assign h_back  = h + 2'd2;
    assign h_right = h + 2'd3;

    // Random walk among the non-mine neighbors; right when all are mines.
    assign rw_dir = (n_free == '0) ? tgw_pkg::DIR_RIGHT
                  : tgw_pkg::sel_nth(free, tgw_pkg::rand_idx(n_free, i_req.rnd_lo,
                                                             i_req.rnd_mod3));

    // Non-backtracking walk over the right, left, down, up candidate list.
    always_comb begin
        if (n_nb != '0) begin
            nb_dir = tgw_pkg::NB_ORDER[tgw_pkg::sel_nth(nb_mask,
                         tgw_pkg::rand_idx(n_nb, i_req.rnd_lo, i_req.rnd_mod3))];
        end else if (n_free == 3'd1) begin
            nb_dir = h;
        end else begin
            nb_dir = tgw_pkg::DIR_RIGHT;
        end
    end

    // Greedy walks prefer blank neighbors.
    assign gb_dir = (n_blank != '0) ? tgw_pkg::sel_nth(blank, 2'd0) : rw_dir;
    assign gu_dir = (n_blank != '0)
                  ? tgw_pkg::sel_nth(blank, tgw_pkg::rand_idx(n_blank, i_req.rnd_lo,
                                                              i_req.rnd_mod3))
                  : rw_dir;

    // Strategy selection and heading update.
    always_comb begin
        o_rsp.dir        = tgw_pkg::DIR_RIGHT;
        o_rsp.heading_we = 1'b0;
        o_rsp.heading    = h;
        unique case (i_req.strategy)
            tgw_pkg::STRAT_RANDOM: begin
                o_rsp.dir = rw_dir;
            end
            tgw_pkg::STRAT_NOBACK: begin
                o_rsp.dir        = nb_dir;
                o_rsp.heading_we = 1'b1;
                o_rsp.heading    = nb_dir ^ 2'd2;
            end
            tgw_pkg::STRAT_GREEDY_B: begin
                o_rsp.dir = gb_dir;
            end
            tgw_pkg::STRAT_GREEDY_U: begin
                o_rsp.dir = gu_dir;
            end
            tgw_pkg::STRAT_CBLIND: begin
                priority if (blank[h_left]) begin
                    o_rsp.dir        = h_left;
                    o_rsp.heading_we = 1'b1;
                    o_rsp.heading    = h_left;
                end else if (blank[h]) begin
                    o_rsp.dir        = h;
                    o_rsp.heading_we = 1'b1;
                    o_rsp.heading    = h;
                end else if (blank[h_right]) begin
                    o_rsp.dir        = h_right;
                    o_rsp.heading_we = 1'b1;
                    o_rsp.heading    = h_right;
                end else begin
                    o_rsp.dir = rw_dir;
                end
            end
            tgw_pkg::STRAT_FOLLOW: begin
                priority if (open == '0) begin
                    o_rsp.dir = rw_dir;
                end else if (open[h_left]) begin
                    o_rsp.dir = h_left;
                end else if (open[h]) begin
                    o_rsp.dir = h;
                end else if (open[h_right]) begin
                    o_rsp.dir = h_right;
                end else begin
                    o_rsp.dir = h_back;
                end
            end
            default: begin
                o_rsp.dir = tgw_pkg::DIR_RIGHT;
            end
        endcase
    end

endmodule

>>> rtl/core/torus_grid_walker_step.sv
// ============================================================================
// torus_grid_walker_step
// One agent walking a wrapping grid of byte cells held in a single RAM.
// ============================================================================
//
// Channel   Ports                              Transfer
// --------  ---------------------------------  -------------------------------
// command   start, busy, i_item                start high while busy is low
// result    o_done, o_result                   o_done high for one cycle
// config    i_cfg_we, i_cfg_idx, i_cfg_data    i_cfg_we high, no wait
//
// In a step, four neighbor reads go through the single read port of the grid
// RAM in S_LOOK, S_LAST collects the last read, S_DECIDE decides and writes
// back, and the result strobe overlaps the next idle cycle. A cell write or
// a placement passes through S_WRITE or S_PLACE, a read through S_READ and
// S_READ_CAP. After reset the grid RAM is cleared one cell a cycle; busy stays
// high until all 65536 cells are cleared. Configuration writes go on meanwhile.
// The receiver cannot stall: every result is presented for exactly one cycle.
//
module torus_grid_walker_step (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  tgw_pkg::t_item                    i_item,
    output logic                              o_done,
    output tgw_pkg::t_result                  o_result,
    input  logic                              i_cfg_we,
    input  logic [tgw_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tgw_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_LAST,
        S_DECIDE,
        S_WRITE,
        S_PLACE,
        S_READ,
        S_READ_CAP
    } t_state;

    t_state r_state;

    logic [1:0]                    r_cnt;
    logic [tgw_pkg::ADDR_W-1:0]    r_clr_addr;
    logic [tgw_pkg::CRD_W-1:0]     r_cx;
    logic [tgw_pkg::CRD_W-1:0]     r_cy;
    logic [tgw_pkg::CELL_W-1:0]    r_val;
    logic [1:0]                    r_rnd_lo;
    logic [1:0]                    r_rnd_mod3;
    logic [3:0][tgw_pkg::CELL_W-1:0] r_nbr;

    logic [tgw_pkg::CRD_W-1:0]     r_pos_x;
    logic [tgw_pkg::CRD_W-1:0]     r_pos_y;
    logic [1:0]                    r_heading;
    logic [tgw_pkg::AREA_W-1:0]    r_area;
    logic [2:0]                    r_strategy;
    logic [tgw_pkg::CELL_W-1:0]    r_agent_mark;
    logic [tgw_pkg::CELL_W-1:0]    r_mine_mark;
    logic                          r_done;
    tgw_pkg::t_result              r_result;

    logic                          ram_we;
    logic [tgw_pkg::ADDR_W-1:0]    ram_waddr;
    logic [tgw_pkg::CELL_W-1:0]    ram_wdata;
    logic                          ram_re;
    logic [tgw_pkg::ADDR_W-1:0]    ram_raddr;
    logic [tgw_pkg::CELL_W-1:0]    ram_rdata;

    tgw_pkg::t_pick_req            pick_req;
    tgw_pkg::t_pick_rsp            pick_rsp;

    logic [tgw_pkg::CELL_W-1:0]    tgt_cell;
    logic [tgw_pkg::CRD_W-1:0]     tgt_x;
    logic [tgw_pkg::CRD_W-1:0]     tgt_y;
    logic                          step_move;
    logic                          step_claim;
    logic [tgw_pkg::AREA_W-1:0]    n_area;
    logic [tgw_pkg::CRD_W-1:0]     n_pos_x;
    logic [tgw_pkg::CRD_W-1:0]     n_pos_y;
    logic                          accept;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // Direction choice from the collected neighbor cells.
    assign pick_req.cells      = r_nbr;
    assign pick_req.strategy   = r_strategy;
    assign pick_req.heading    = r_heading;
    assign pick_req.agent_mark = r_agent_mark;
    assign pick_req.mine_mark  = r_mine_mark;
    assign pick_req.rnd_lo     = r_rnd_lo;
    assign pick_req.rnd_mod3   = r_rnd_mod3;

    tgw_dir_pick u_pick (
        .i_req (pick_req),
        .o_rsp (pick_rsp)
    );

    // Outcome of the step at the chosen target cell.
    always_comb begin
        tgt_cell   = r_nbr[pick_rsp.dir];
        tgt_x      = tgw_pkg::target_x(r_pos_x, pick_rsp.dir);
        tgt_y      = tgw_pkg::target_y(r_pos_y, pick_rsp.dir);
        step_move  = (tgt_cell != r_mine_mark);
        step_claim = step_move && (tgt_cell == '0);
        n_area     = (step_claim && (r_area != '1)) ? r_area + 1'b1 : r_area;
        n_pos_x    = step_move ? tgt_x : r_pos_x;
        n_pos_y    = step_move ? tgt_y : r_pos_y;
    end

    // Grid RAM access: clearing sweep, cell writes and claims, reads.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = {r_cx, r_cy};
        ram_wdata = r_val;
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
            end
            S_WRITE: begin
                ram_we = 1'b1;
            end
            S_DECIDE: begin
                ram_we    = step_claim;
                ram_waddr = {tgt_x, tgt_y};
                ram_wdata = r_agent_mark;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
        ram_re    = (r_state == S_LOOK) || (r_state == S_READ);
        ram_raddr = (r_state == S_LOOK)
                  ? {tgw_pkg::target_x(r_pos_x, r_cnt), tgw_pkg::target_y(r_pos_y, r_cnt)}
                  : {r_cx, r_cy};
    end

    tgw_grid_ram #(
        .ADDR_W (tgw_pkg::ADDR_W),
        .DATA_W (tgw_pkg::CELL_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strategy   <= tgw_pkg::RST_STRATEGY;
            r_agent_mark <= tgw_pkg::RST_AGENT_MARK;
            r_mine_mark  <= tgw_pkg::RST_MINE_MARK;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tgw_pkg::CFG_STRATEGY:   r_strategy   <= i_cfg_data[2:0];
                tgw_pkg::CFG_AGENT_MARK: r_agent_mark <= i_cfg_data;
                tgw_pkg::CFG_MINE_MARK:  r_mine_mark  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer: walker state, transaction capture and registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_cnt      <= '0;
            r_clr_addr <= '0;
            r_pos_x    <= '0;
            r_pos_y    <= '0;
            r_heading  <= tgw_pkg::DIR_RIGHT;
            r_area     <= '0;
            r_done     <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_cx       <= i_item.cell_x[tgw_pkg::CRD_W-1:0];
                        r_cy       <= i_item.cell_y[tgw_pkg::CRD_W-1:0];
                        r_val      <= i_item.cell_value;
                        r_rnd_lo   <= i_item.random_value[1:0];
                        r_rnd_mod3 <= tgw_pkg::mod3_u16(i_item.random_value);
                        r_cnt      <= '0;
                        unique case (i_item.operation)
                            tgw_pkg::OP_STEP:  r_state <= S_LOOK;
                            tgw_pkg::OP_WRITE: r_state <= S_WRITE;
                            tgw_pkg::OP_PLACE: r_state <= S_PLACE;
                            default:           r_state <= S_READ;
                        endcase
                    end
                end
                S_LOOK: begin
                    // Read data arrives in the cycle after its address is issued.
                    if (r_cnt != 2'd0) begin
                        r_nbr[r_cnt - 2'd1] <= ram_rdata;
                    end
                    r_cnt <= r_cnt + 2'd1;
                    if (r_cnt == 2'd3) begin
                        r_state <= S_LAST;
                    end
                end
                S_LAST: begin
                    r_nbr[3] <= ram_rdata;
                    r_state  <= S_DECIDE;
                end
                S_DECIDE: begin
                    r_pos_x <= n_pos_x;
                    r_pos_y <= n_pos_y;
                    r_area  <= n_area;
                    if (pick_rsp.heading_we) begin
                        r_heading <= pick_rsp.heading;
                    end
                    r_result.pos_x            <= 8'(n_pos_x);
                    r_result.pos_y            <= 8'(n_pos_y);
                    r_result.chosen_direction <= pick_rsp.dir;
                    r_result.moved            <= step_move;
                    r_result.area_count       <= n_area;
                    r_result.read_data        <= '0;
                    r_done                    <= 1'b1;
                    r_state                   <= S_IDLE;
                end
                S_WRITE: begin
                    r_result.pos_x            <= 8'(r_pos_x);
                    r_result.pos_y            <= 8'(r_pos_y);
                    r_result.chosen_direction <= tgw_pkg::DIR_RIGHT;
                    r_result.moved            <= 1'b0;
                    r_result.area_count       <= r_area;
                    r_result.read_data        <= '0;
                    r_done                    <= 1'b1;
                    r_state                   <= S_IDLE;
                end
                S_PLACE: begin
                    r_pos_x   <= r_cx;
                    r_pos_y   <= r_cy;
                    r_heading <= tgw_pkg::DIR_RIGHT;
                    r_area    <= '0;
                    r_result.pos_x            <= 8'(r_cx);
                    r_result.pos_y            <= 8'(r_cy);
                    r_result.chosen_direction <= tgw_pkg::DIR_RIGHT;
                    r_result.moved            <= 1'b0;
                    r_result.area_count       <= '0;
                    r_result.read_data        <= '0;
                    r_done                    <= 1'b1;
                    r_state                   <= S_IDLE;
                end
                S_READ: begin
                    r_state <= S_READ_CAP;
                end
                S_READ_CAP: begin
                    r_result.pos_x            <= 8'(r_pos_x);
                    r_result.pos_y            <= 8'(r_pos_y);
                    r_result.chosen_direction <= tgw_pkg::DIR_RIGHT;
                    r_result.moved            <= 1'b0;
                    r_result.area_count       <= r_area;
                    r_result.read_data        <= ram_rdata;
                    r_done                    <= 1'b1;
                    r_state                   <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    // A result strobe only follows a finishing state.
    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_DECIDE || r_state == S_WRITE ||
                         r_state == S_PLACE || r_state == S_READ_CAP))
        else $error("result strobe without a finishing state");

    // An accepted transaction makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // The block is ready again when its result is presented.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result presented while still busy");

    // A step never lowers the claimed area count.
    a_area_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE) |=> (r_area >= $past(r_area)))
        else $error("step lowered the area count");

endmodule
